>>> src/bmmmd_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bmmmd_pkg
// shared item types and sizing constants for the block statistics unit
// ---------------------------------------------------------------------------
package bmmmd_pkg;

  // sample store depth and the widths that follow from it
  localparam int DEPTH      = 64;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // fixed field widths
  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = 22;
  localparam int DIV_CNT_W  = $clog2(SUM_W + 1);

  // one input item
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic signed [SUM_W-1:0]    total;
    logic signed [SAMPLE_W-1:0] mean;
    logic signed [SAMPLE_W-1:0] smallest;
    logic signed [SAMPLE_W-1:0] largest;
    logic        [SAMPLE_W-1:0] min_deviation;
    logic        [SAMPLE_W-1:0] max_deviation;
    logic                       overflowed;
  } out_item_t;

endpackage : bmmmd_pkg
`default_nettype wire

>>> src/bmmmd_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bmmmd_div
// serial restoring divider, one quotient bit per cycle, unsigned operands
// ---------------------------------------------------------------------------
module bmmmd_div
  import bmmmd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [SUM_W-1:0] dividend,
  input  wire logic [CNT_W-1:0] divisor,
  output logic                  busy,
  output logic      [SUM_W-1:0] quotient
);

  logic                 busy_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [CNT_W:0]       rem_r;
  logic [CNT_W:0]       rem_sh;
  logic [CNT_W:0]       rem_nxt;
  logic [SUM_W-1:0]     quo_r;
  logic [SUM_W-1:0]     quo_nxt;
  logic [CNT_W-1:0]     dsr_r;
  logic                 fits;

  // shift in the next dividend bit and try a subtract
  always_comb begin
    rem_sh  = {rem_r[CNT_W-1:0], quo_r[SUM_W-1]};
    fits    = rem_sh >= {1'b0, dsr_r};
    rem_nxt = fits ? (rem_sh - {1'b0, dsr_r}) : rem_sh;
    quo_nxt = {quo_r[SUM_W-2:0], fits};
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_CNT_W'(SUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule : bmmmd_div
`default_nettype wire

>>> src/block_min_max_mean_deviation.sv
`default_nettype none
// ---------------------------------------------------------------------------
// block_min_max_mean_deviation
// block statistics: sum, mean, min, max and min/max absolute deviation
// ---------------------------------------------------------------------------
// usage
//   in_valid/in_stall carry one signed Q8.8 sample per item, last_sample
//   marks the end of a block. up to DEPTH samples are kept; later ones are
//   dropped and set the overflow flag of the result.
//   samples are taken one per cycle while the block is loading.
//   after the last sample the sequencer runs its steps in order: it starts
//   the divider, waits on the serial divider for the mean, latches the
//   mean, scans the kept samples out of the single read port of the store
//   and emits the result; in_stall is high meanwhile.
//   the result sits in an output register; a new block loads while it
//   waits, and the sequencer holds in its emit step only if the next
//   result is ready while out_stall still holds the previous one.
//   reset clears the counters and flags and returns to loading; the
//   sample store has no reset.
// ---------------------------------------------------------------------------
module block_min_max_mean_deviation
  import bmmmd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  // sequencer steps
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_MEAN,
    ST_SCAN,
    ST_EMIT
  } step_t;

  // jump conditions
  typedef enum logic [2:0] {
    CND_NONE,
    CND_NO_LAST,
    CND_DIV_BUSY,
    CND_SCAN_MORE,
    CND_OUT_BLOCKED
  } cond_t;

  typedef struct packed {
    logic  in_open;
    logic  div_start;
    logic  mean_load;
    logic  scan;
    logic  emit;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  // microprogram: jump to target when cond holds, else fall through
  function automatic ctrl_word_t ucode(input step_t step);
    ctrl_word_t cw;
    cw = '{in_open: 1'b0, div_start: 1'b0, mean_load: 1'b0, scan: 1'b0,
           emit: 1'b0, cond: CND_NONE, target: ST_LOAD};
    case (step)
      ST_LOAD: begin
        cw.in_open = 1'b1;
        cw.cond    = CND_NO_LAST;
        cw.target  = ST_LOAD;
      end
      ST_DIV_GO: begin
        cw.div_start = 1'b1;
      end
      ST_DIV_WAIT: begin
        cw.cond   = CND_DIV_BUSY;
        cw.target = ST_DIV_WAIT;
      end
      ST_MEAN: begin
        cw.mean_load = 1'b1;
      end
      ST_SCAN: begin
        cw.scan   = 1'b1;
        cw.cond   = CND_SCAN_MORE;
        cw.target = ST_SCAN;
      end
      ST_EMIT: begin
        cw.emit   = 1'b1;
        cw.cond   = CND_OUT_BLOCKED;
        cw.target = ST_EMIT;
      end
      default: begin
        cw.target = ST_LOAD;
        cw.cond   = CND_NONE;
      end
    endcase
    return cw;
  endfunction

  step_t      pc_r, pc_nxt;
  ctrl_word_t cw;
  logic       cond_true;

  logic                       in_accept;
  logic                       keep;
  logic                       out_blocked;
  logic                       emit_fire;
  logic                       out_valid_r;
  out_item_t                  out_data_r;

  logic [CNT_W-1:0]           count_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic                       overflow_r;
  logic signed [SAMPLE_W-1:0] min_r;
  logic signed [SAMPLE_W-1:0] max_r;
  logic signed [SAMPLE_W-1:0] mean_r;
  logic [SAMPLE_W-1:0]        dmin_r;
  logic [SAMPLE_W-1:0]        dmax_r;
  logic [CNT_W-1:0]           idx_r;
  logic                       first_r;

  logic signed [SAMPLE_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0]          rd_addr;
  logic signed [SAMPLE_W-1:0] rd_data_r;

  logic                       sum_neg;
  logic [SUM_W-1:0]           sum_mag;
  logic                       div_busy;
  logic [SUM_W-1:0]           quotient;
  logic [SAMPLE_W-1:0]        quo_low;

  logic signed [SAMPLE_W:0]   diff;
  logic [SAMPLE_W:0]          diff_mag;
  logic [SAMPLE_W-1:0]        dev;

  // control word and next step
  always_comb begin
    cw        = ucode(pc_r);
    in_accept = in_valid && cw.in_open;
    case (cw.cond)
      CND_NONE:        cond_true = 1'b0;
      CND_NO_LAST:     cond_true = !(in_accept && in_data.last_sample);
      CND_DIV_BUSY:    cond_true = div_busy;
      CND_SCAN_MORE:   cond_true = idx_r != count_r;
      CND_OUT_BLOCKED: cond_true = out_blocked;
      default:         cond_true = 1'b0;
    endcase
    if (cond_true) begin
      pc_nxt = cw.target;
    end else if (pc_r == ST_EMIT) begin
      pc_nxt = ST_LOAD;
    end else begin
      pc_nxt = step_t'(pc_r + 3'd1);
    end
  end

  assign in_stall    = !cw.in_open;
  assign keep        = in_accept && (count_r < CNT_W'(DEPTH));
  assign out_blocked = out_valid_r && out_stall;
  assign emit_fire   = cw.emit && !out_blocked;

  // sequencer, counters and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= ST_LOAD;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      sum_r       <= '0;
      overflow_r  <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (emit_fire) begin
        count_r    <= '0;
        sum_r      <= '0;
        overflow_r <= 1'b0;
      end else if (keep) begin
        count_r <= count_r + CNT_W'(1);
        sum_r   <= sum_r + SUM_W'(in_data.sample);
      end else if (in_accept) begin
        overflow_r <= 1'b1;
      end
    end
  end

  // running min and max, first kept sample replaces both
  always_ff @(posedge clk) begin
    if (keep) begin
      if (count_r == '0) begin
        min_r <= in_data.sample;
        max_r <= in_data.sample;
      end else begin
        if (in_data.sample < min_r) min_r <= in_data.sample;
        if (in_data.sample > max_r) max_r <= in_data.sample;
      end
    end
  end

  // sample store, one write and one registered read port
  assign rd_addr = cw.scan ? idx_r[ADDR_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (keep) begin
      mem[count_r[ADDR_W-1:0]] <= in_data.sample;
    end
    rd_data_r <= mem[rd_addr];
  end

  // mean: divide the magnitude of the sum, then restore the sign
  assign sum_neg = sum_r[SUM_W-1];
  assign sum_mag = sum_neg ? (SUM_W'(0) - sum_r) : sum_r;
  assign quo_low = quotient[SAMPLE_W-1:0];

  bmmmd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cw.div_start),
    .dividend (sum_mag),
    .divisor  (count_r),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // absolute deviation of the sample read last cycle
  always_comb begin
    diff     = {rd_data_r[SAMPLE_W-1], rd_data_r} - {mean_r[SAMPLE_W-1], mean_r};
    diff_mag = diff[SAMPLE_W] ? ((SAMPLE_W + 1)'(0) - diff) : diff;
    dev      = diff_mag[SAMPLE_W-1:0];
  end

  // mean latch and deviation scan
  always_ff @(posedge clk) begin
    if (cw.mean_load) begin
      mean_r  <= sum_neg ? (SAMPLE_W'(0) - quo_low) : quo_low;
      idx_r   <= CNT_W'(1);
      first_r <= 1'b1;
    end else if (cw.scan) begin
      idx_r   <= idx_r + CNT_W'(1);
      first_r <= 1'b0;
      if (first_r) begin
        dmin_r <= dev;
        dmax_r <= dev;
      end else begin
        if (dev < dmin_r) dmin_r <= dev;
        if (dev > dmax_r) dmax_r <= dev;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_data_r.total         <= sum_r;
      out_data_r.mean          <= mean_r;
      out_data_r.smallest      <= min_r;
      out_data_r.largest       <= max_r;
      out_data_r.min_deviation <= dmin_r;
      out_data_r.max_deviation <= dmax_r;
      out_data_r.overflowed    <= overflow_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule : block_min_max_mean_deviation
`default_nettype wire
